[hw/rtl/deq_pkg.sv]
// shared types, constants and index helpers for the double-ended queue
// no dependencies; used by every module of the block except deq_ram
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  // storage geometry
  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = IDX_W + 1;
  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int STS_W  = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP_FWD   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DUMP_BWD   = 3'd5;

  // result status codes
  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic             do_push;
    logic             do_pop;
    logic             at_front;    // push/pop end, or forward direction for a dump
    logic             start_dump;
    logic             step_dump;
    logic             load_imm;
    logic [STS_W-1:0] imm_status;
    logic             load_mem;
    logic             mem_last;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic dump_last;
    logic out_busy;
  } dp_stat_t;

  // circular slot of the entry at a given offset from the front
  function automatic logic [IDX_W-1:0] slot_f(input logic [IDX_W-1:0] front,
                                             input logic [IDX_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = {1'b0, front} + {1'b0, off};
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/double_ended_queue.sv]
// Double-ended queue of signed 32-bit values, 16 entries in a ring.
//
// Input channel (in_valid / in_stall): one transaction carries in_command
// and in_value. Commands push at the front or back, pop from the front or
// back, or dump all entries front-to-back or back-to-front. Codes 6 and 7
// are taken and give no result.
// Result channel (out_valid / out_stall): out_status, out_data, out_last.
// Push and pop give one result; a dump gives one result per stored entry
// with out_last on the final one, or a single empty result.
// Push, full-push, empty-pop and empty-dump results are registered in the
// cycle after the transaction; a pop result and each dump entry pass
// through the registered read of the entry memory and then the result
// register, and further dump entries follow one per cycle while the
// receiver does not stall. Push commands are accepted every cycle while
// results drain; a pop or a dump holds the input until its last entry is loaded.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result. When the receiver stalls, the result register holds its payload
// and no new transaction or dump step is taken until it drains.
// depends on deq_pkg, deq_ctrl, deq_dp
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic        [deq_pkg::CMD_W-1:0]  in_command,
  input  wire logic signed [deq_pkg::DATA_W-1:0] in_value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic        [deq_pkg::STS_W-1:0]       out_status,
  output logic signed [deq_pkg::DATA_W-1:0]      out_data,
  output logic                                   out_last
);

  deq_pkg::ctrl_cmd_t cmd;
  deq_pkg::dp_stat_t  stat;

  // command decode and sequencing
  deq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // storage, pointers and result register
  deq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_value),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_data   (out_data),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire

[hw/rtl/deq_ram.sv]
// generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/deq_ctrl.sv]
// controller state machine: decodes commands and sequences pops and dumps
// depends on deq_pkg
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [deq_pkg::CMD_W-1:0] in_command,
  output logic                           in_stall,
  input  wire deq_pkg::dp_stat_t         stat,
  output deq_pkg::ctrl_cmd_t             cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOAD = 1'b1;

  logic state_r, state_nxt;
  logic dump_r, dump_nxt;
  logic take;

  // a new transaction waits for the result register to drain and for a pop or dump to finish
  assign in_stall = (state_r != S_IDLE) || stat.out_busy;
  assign take     = in_valid && !in_stall;

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    dump_nxt  = dump_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          unique case (in_command) inside
            deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
              cmd.load_imm = 1'b1;
              cmd.at_front = (in_command == deq_pkg::CMD_PUSH_FRONT);
              if (stat.full) begin
                cmd.imm_status = deq_pkg::STS_FULL;
              end else begin
                cmd.imm_status = deq_pkg::STS_OK;
                cmd.do_push    = 1'b1;
              end
            end
            deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
              cmd.at_front = (in_command == deq_pkg::CMD_POP_FRONT);
              if (stat.empty) begin
                cmd.load_imm   = 1'b1;
                cmd.imm_status = deq_pkg::STS_EMPTY;
              end else begin
                cmd.do_pop = 1'b1;
                dump_nxt   = 1'b0;
                state_nxt  = S_LOAD;
              end
            end
            deq_pkg::CMD_DUMP_FWD, deq_pkg::CMD_DUMP_BWD: begin
              cmd.at_front = (in_command == deq_pkg::CMD_DUMP_FWD);
              if (stat.empty) begin
                cmd.load_imm   = 1'b1;
                cmd.imm_status = deq_pkg::STS_EMPTY;
              end else begin
                cmd.start_dump = 1'b1;
                dump_nxt       = 1'b1;
                state_nxt      = S_LOAD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LOAD: begin
        // move memory data into the result register once it is free
        if (!stat.out_busy) begin
          cmd.load_mem = 1'b1;
          cmd.mem_last = !dump_r || stat.dump_last;
          if (cmd.mem_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.step_dump = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dump_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dump_r  <= dump_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/deq_dp.sv]
// datapath: front index, entry count, dump cursor, entry memory, result register
// depends on deq_pkg and deq_ram
`timescale 1ns / 1ps
`default_nettype none

module deq_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic signed [deq_pkg::DATA_W-1:0] in_value,
  input  wire deq_pkg::ctrl_cmd_t                cmd,
  output deq_pkg::dp_stat_t                      stat,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic        [deq_pkg::STS_W-1:0]       out_status,
  output logic signed [deq_pkg::DATA_W-1:0]      out_data,
  output logic                                   out_last
);

  localparam int IW = deq_pkg::IDX_W;
  localparam int CW = deq_pkg::CNT_W;

  logic [IW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          fwd_r, fwd_nxt;

  logic                            out_valid_r;
  logic [deq_pkg::STS_W-1:0]       out_status_r;
  logic [deq_pkg::DATA_W-1:0]      out_data_r;
  logic                            out_last_r;

  logic [CW-1:0] cnt_m1;
  logic [IW-1:0] back_off;
  logic [IW-1:0] front_dec;
  logic [IW-1:0] front_inc;
  logic [IW-1:0] rd_off;
  logic          rd_en;
  logic [IW-1:0] raddr;
  logic          we;
  logic [IW-1:0] waddr;
  logic [deq_pkg::DATA_W-1:0] rdata;

  // index arithmetic around the ring
  assign cnt_m1    = count_r - CW'(1);
  assign back_off  = cnt_m1[IW-1:0];
  assign front_dec = (front_r == '0) ? IW'(deq_pkg::DEPTH - 1) : front_r - IW'(1);
  assign front_inc = (front_r == IW'(deq_pkg::DEPTH - 1)) ? '0 : front_r + IW'(1);

  // status toward the controller
  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == CW'(deq_pkg::DEPTH));
  assign stat.dump_last = fwd_r ? (idx_r == back_off) : (idx_r == '0);
  assign stat.out_busy  = out_valid_r && out_stall;

  // read offset selection and cursor update
  always_comb begin
    rd_off  = '0;
    idx_nxt = idx_r;
    fwd_nxt = fwd_r;
    if (cmd.do_pop) begin
      rd_off = cmd.at_front ? '0 : back_off;
    end else if (cmd.start_dump) begin
      rd_off  = cmd.at_front ? '0 : back_off;
      idx_nxt = rd_off;
      fwd_nxt = cmd.at_front;
    end else if (cmd.step_dump) begin
      rd_off  = fwd_r ? idx_r + IW'(1) : idx_r - IW'(1);
      idx_nxt = rd_off;
    end
  end

  assign rd_en = cmd.do_pop || cmd.start_dump || cmd.step_dump;
  assign raddr = deq_pkg::slot_f(front_r, rd_off);

  // push writes and pointer updates
  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    we        = 1'b0;
    waddr     = deq_pkg::slot_f(front_r, count_r[IW-1:0]);
    if (cmd.do_push) begin
      we        = 1'b1;
      count_nxt = count_r + CW'(1);
      if (cmd.at_front) begin
        waddr     = front_dec;
        front_nxt = front_dec;
      end
    end else if (cmd.do_pop) begin
      count_nxt = cnt_m1;
      if (cmd.at_front) begin
        front_nxt = front_inc;
      end
    end
  end

  deq_ram #(
    .WIDTH (deq_pkg::DATA_W),
    .DEPTH (deq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_value),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // pointer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      idx_r   <= '0;
      fwd_r   <= 1'b0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      fwd_r   <= fwd_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_imm || cmd.load_mem) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.load_imm) begin
      out_status_r <= cmd.imm_status;
      out_data_r   <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.load_mem) begin
      out_status_r <= deq_pkg::STS_OK;
      out_data_r   <= rdata;
      out_last_r   <= cmd.mem_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

[sim/double_ended_queue_tb.sv]
// self-checking testbench for the double-ended queue
// holds a shadow ring of the queue and checks every result in order; depends on deq_pkg
`timescale 1ns / 1ps

module double_ended_queue_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [deq_pkg::STS_W-1:0]  status;
    logic [deq_pkg::DATA_W-1:0] data;
    logic                       last;
  } result_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic [deq_pkg::CMD_W-1:0]         in_command;
  logic signed [deq_pkg::DATA_W-1:0] in_value;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [deq_pkg::STS_W-1:0]         out_status;
  logic signed [deq_pkg::DATA_W-1:0] out_data;
  logic                              out_last;

  // shadow copy of the queue contents
  logic [deq_pkg::DATA_W-1:0] shadow_ring [deq_pkg::DEPTH];
  int                         shadow_front;
  int                         shadow_count;

  result_t pending_results[$];
  int      mismatch_count;
  int      items_sent;
  int      burst_left;
  int      idle_cycles = 0;
  int      stall_mode  = 0;
  int      stall_phase = 0;

  double_ended_queue u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_command(in_command),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_status(out_status),
    .out_data  (out_data),
    .out_last  (out_last)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic result_t make_result(logic [deq_pkg::STS_W-1:0] status,
                                          logic [deq_pkg::DATA_W-1:0] data,
                                          logic last);
    result_t r;
    r.status = status;
    r.data   = data;
    r.last   = last;
    return r;
  endfunction

  function automatic int ring_slot(int offset);
    return (shadow_front + offset) % deq_pkg::DEPTH;
  endfunction

  // extremes now and then, otherwise any 32-bit pattern
  function automatic logic [deq_pkg::DATA_W-1:0] random_value();
    case ($urandom_range(0, 15))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // update the shadow queue and queue up the results one command causes
  task automatic apply_command(input logic [deq_pkg::CMD_W-1:0] cmd,
                               input logic [deq_pkg::DATA_W-1:0] val);
    logic [deq_pkg::DATA_W-1:0] word;
    int                         offset;
    case (cmd)
      deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
        if (shadow_count >= deq_pkg::DEPTH) begin
          pending_results.push_back(make_result(deq_pkg::STS_FULL, '0, 1'b1));
        end else begin
          if (cmd == deq_pkg::CMD_PUSH_FRONT) begin
            shadow_front = (shadow_front + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
            shadow_ring[shadow_front] = val;
          end else begin
            shadow_ring[ring_slot(shadow_count)] = val;
          end
          shadow_count++;
          pending_results.push_back(make_result(deq_pkg::STS_OK, '0, 1'b1));
        end
      end
      deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
        if (shadow_count == 0) begin
          pending_results.push_back(make_result(deq_pkg::STS_EMPTY, '0, 1'b1));
        end else begin
          if (cmd == deq_pkg::CMD_POP_FRONT) begin
            word = shadow_ring[shadow_front];
            shadow_front = ring_slot(1);
          end else begin
            word = shadow_ring[ring_slot(shadow_count - 1)];
          end
          shadow_count--;
          pending_results.push_back(make_result(deq_pkg::STS_OK, word, 1'b1));
        end
      end
      deq_pkg::CMD_DUMP_FWD, deq_pkg::CMD_DUMP_BWD: begin
        if (shadow_count == 0) begin
          pending_results.push_back(make_result(deq_pkg::STS_EMPTY, '0, 1'b1));
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            offset = (cmd == deq_pkg::CMD_DUMP_FWD) ? i : shadow_count - 1 - i;
            pending_results.push_back(make_result(deq_pkg::STS_OK,
                                                  shadow_ring[ring_slot(offset)],
                                                  i + 1 == shadow_count));
          end
        end
      end
      default: ;
    endcase
  endtask

  // send one transaction, in bursts with random gaps in between
  task automatic send_cmd(input logic [deq_pkg::CMD_W-1:0] cmd,
                          input logic [deq_pkg::DATA_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_value   <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_command(cmd, val);
    burst_left--;
    items_sent++;
  endtask

  // hold the input until every queued result has come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // pops and dumps on an empty queue, plus the two unused codes
  task automatic test_empty_queue();
    send_cmd(deq_pkg::CMD_POP_FRONT, random_value());
    send_cmd(deq_pkg::CMD_POP_BACK, random_value());
    send_cmd(deq_pkg::CMD_DUMP_FWD, random_value());
    send_cmd(deq_pkg::CMD_DUMP_BWD, random_value());
    send_cmd(3'd6, random_value());
    send_cmd(3'd7, random_value());
  endtask

  // extreme values through both ends, dumped both ways, then popped from both ends
  task automatic test_value_extremes();
    send_cmd(deq_pkg::CMD_PUSH_FRONT, 32'h7fff_ffff);
    send_cmd(deq_pkg::CMD_PUSH_BACK, 32'h8000_0000);
    send_cmd(deq_pkg::CMD_PUSH_FRONT, 32'h0000_0000);
    send_cmd(deq_pkg::CMD_PUSH_BACK, 32'hffff_ffff);
    send_cmd(deq_pkg::CMD_PUSH_FRONT, 32'h5a5a_a5a5);
    send_cmd(deq_pkg::CMD_DUMP_FWD, 32'hffff_ffff);
    send_cmd(deq_pkg::CMD_DUMP_BWD, 32'h0000_0000);
    send_cmd(deq_pkg::CMD_POP_FRONT, random_value());
    send_cmd(deq_pkg::CMD_POP_BACK, random_value());
    send_cmd(deq_pkg::CMD_POP_FRONT, random_value());
    send_cmd(deq_pkg::CMD_POP_BACK, random_value());
    send_cmd(deq_pkg::CMD_POP_BACK, random_value());
  endtask

  // fill to the top from random ends, push past full, dump, then drain past empty
  task automatic test_fill_and_overflow();
    while (shadow_count < deq_pkg::DEPTH) begin
      send_cmd($urandom_range(0, 1) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT,
               random_value());
    end
    send_cmd(deq_pkg::CMD_PUSH_FRONT, random_value());
    send_cmd(deq_pkg::CMD_PUSH_BACK, random_value());
    send_cmd(deq_pkg::CMD_DUMP_FWD, random_value());
    send_cmd(deq_pkg::CMD_DUMP_BWD, random_value());
    while (shadow_count > 0) begin
      send_cmd($urandom_range(0, 1) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT,
               random_value());
    end
    send_cmd($urandom_range(0, 1) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT,
             random_value());
  endtask

  // segments that lean toward growing, shrinking or neither
  task automatic test_random_traffic(input int target);
    int                        first_item;
    int                        push_pct;
    int                        seg_len;
    int                        pick;
    logic [deq_pkg::CMD_W-1:0] cmd;
    first_item = items_sent;
    while (items_sent - first_item < target) begin
      case ($urandom_range(0, 2))
        0: push_pct = 75;
        1: push_pct = 25;
        default: push_pct = 50;
      endcase
      seg_len = $urandom_range(5, 30);
      repeat (seg_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          cmd = deq_pkg::CMD_W'($urandom_range(6, 7));
        end else if (pick < 11) begin
          cmd = $urandom_range(0, 1) ? deq_pkg::CMD_DUMP_BWD : deq_pkg::CMD_DUMP_FWD;
        end else if (pick < 11 + push_pct * 89 / 100) begin
          cmd = $urandom_range(0, 1) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT;
        end else begin
          cmd = $urandom_range(0, 1) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT;
        end
        send_cmd(cmd, random_value());
      end
    end
  endtask

  // receiver stall pattern, switching style each time the phase counter wraps
  always @(negedge clk) begin
    stall_phase = stall_phase + 1;
    if (stall_phase == 48) begin
      stall_phase = 0;
      stall_mode  = $urandom_range(0, 3);
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (stall_phase % 4 < 2);
      endcase
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: out_status %0d out_data %0d out_last %0d",
               out_status, out_data, out_last);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("out_status mismatch: expected %0d, actual %0d", want.status, out_status);
          mismatch_count++;
        end
        if (out_data !== want.data) begin
          $error("out_data mismatch: expected %0d, actual %0d", $signed(want.data), out_data);
          mismatch_count++;
        end
        if (out_last !== want.last) begin
          $error("out_last mismatch: expected %0d, actual %0d", want.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = '0;
    in_value       = '0;
    shadow_front   = 0;
    shadow_count   = 0;
    mismatch_count = 0;
    items_sent     = 0;
    burst_left     = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_value_extremes();
    wait_drained();
    test_fill_and_overflow();
    wait_drained();
    test_random_traffic(85);
    test_fill_and_overflow();

    // let the last results out and watch for strays
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
